FILE: rtl/md5_message_digest_assert.svh
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
// implication checked every cycle outside reset
`define MD5_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("md5 check failed");
// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("md5 check failed");
`endif

FILE: rtl/md5_pkg.sv
package md5_pkg;
    localparam int LENGTH_BITS = 64;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       is_last;
    } t_req;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
              32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
              32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
              32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
              32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
              32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
              32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
              32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
              32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
              32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
              32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
              32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
              32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] j);
        logic [4:0] r [16];
        r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return r[j];
    endfunction
endpackage

FILE: rtl/md5_front.sv
module md5_front
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_req        o_req
);
    t_req       r_q [QDEPTH];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       push, pop, keep;

    // items with neither byte nor end are dropped here
    assign keep    = i_req.byte_valid | i_req.is_last;
    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign push    = i_valid & o_ready & keep;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid & i_ready;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: rtl/md5_back.sv
module md5_back
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_req         i_req,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [127:0] o_digest
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_PAD = 3'd2, S_OUT = 3'd3;

    logic [2:0]  r_st;
    logic [31:0] r_buf [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [63:0] r_cnt;
    logic [5:0]  r_i;
    logic        r_fin;   // current compression belongs to the final padding
    logic        r_two;   // length block still to run
    logic        r_pad;   // padding still due after the current data block
    logic [5:0]  pos;
    logic [3:0]  wi, g;
    logic [1:0]  bi;
    logic [31:0] f, t, rot, sum;
    logic [63:0] bits;
    logic [4:0]  s;

    assign pos = r_cnt[5:0];
    assign wi  = pos[5:2];
    assign bi  = pos[1:0];
    assign bits = (r_cnt << 3) & {{(64-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_digest = {r_h[3], r_h[2], r_h[1], r_h[0]};

    always_comb begin
        unique case (r_i[5:4])
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_i[3:0]; end
            2'd1: begin f = (r_d & r_b) | (~r_d & r_c); g = 4'(5*r_i + 1); end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = 4'(3*r_i + 5); end
            default: begin f = r_c ^ (r_b | ~r_d);      g = 4'(7*r_i); end
        endcase
        sum = r_a + f + round_const(r_i) + r_buf[g];
        s   = rot_amount({r_i[5:4], r_i[1:0]});
        t   = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
        rot = r_b + t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_i   <= '0;
            r_fin <= 1'b0;
            r_two <= 1'b0;
            r_pad <= 1'b0;
            r_h[0] <= INIT_A; r_h[1] <= INIT_B; r_h[2] <= INIT_C; r_h[3] <= INIT_D;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    if (i_req.byte_valid) begin
                        r_buf[wi] <= (bi == 2'd0) ? {24'd0, i_req.data_byte} :
                            (r_buf[wi] & ((32'd1 << {bi, 3'd0}) - 32'd1)) |
                            ({24'd0, i_req.data_byte} << {bi, 3'd0});
                        r_cnt <= r_cnt + 64'd1;
                    end
                    r_pad <= i_req.is_last;
                    if (i_req.byte_valid && pos == 6'd63) begin
                        r_st <= S_RUN;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                        r_i <= '0;
                    end else if (i_req.is_last) begin
                        r_st <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_buf[wi] <= (bi == 2'd0) ? {24'd0, PAD_BYTE} :
                        (r_buf[wi] & ((32'd1 << {bi, 3'd0}) - 32'd1)) |
                        ({24'd0, PAD_BYTE} << {bi, 3'd0});
                    for (int k = 0; k < 16; k++) begin
                        if (4'(k) > wi) begin
                            if (pos < 6'd56 && k == 14) r_buf[k] <= bits[31:0];
                            else if (pos < 6'd56 && k == 15) r_buf[k] <= bits[63:32];
                            else r_buf[k] <= '0;
                        end
                    end
                    r_two <= (pos >= 6'd56);
                    r_fin <= 1'b1;
                    r_pad <= 1'b0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                    r_i <= '0;
                    r_st <= S_RUN;
                end
                S_RUN: begin
                    if (r_i != 6'd63) begin
                        r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= rot;
                        r_i <= r_i + 6'd1;
                    end else begin
                        r_i <= '0;
                        r_h[0] <= r_h[0] + r_d;
                        r_h[1] <= r_h[1] + rot;
                        r_h[2] <= r_h[2] + r_b;
                        r_h[3] <= r_h[3] + r_c;
                        if (!r_fin) begin
                            r_st <= r_pad ? S_PAD : S_IDLE;
                        end else if (r_two) begin
                            r_two <= 1'b0;
                            for (int k = 0; k < 14; k++) r_buf[k] <= '0;
                            r_buf[14] <= bits[31:0];
                            r_buf[15] <= bits[63:32];
                            r_a <= r_h[0] + r_d; r_b <= r_h[1] + rot;
                            r_c <= r_h[2] + r_b; r_d <= r_h[3] + r_c;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: if (i_ready) begin
                    r_st  <= S_IDLE;
                    r_cnt <= '0;
                    r_fin <= 1'b0;
                    r_pad <= 1'b0;
                    r_h[0] <= INIT_A; r_h[1] <= INIT_B; r_h[2] <= INIT_C; r_h[3] <= INIT_D;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/md5_message_digest.sv
// bytes pass through a registered queue and are written into the block buffer while idle
// the compression loop runs one round per cycle, and no bytes are taken while it runs
// end of message: a pad step, then one or two compressions before the digest shows
// a 2-entry queue lets bytes arrive while a block is compressed
// synchronous active-low reset restores the initial chaining words and clears the count
module md5_message_digest
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic         s_axis_tuser,  // byte_valid
    input  logic         s_axis_tlast,  // is_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // digest_word0..digest_word3
);
    t_req in_req, q_req;
    logic q_valid, q_ready;

    assign in_req = '{data_byte: s_axis_tdata, byte_valid: s_axis_tuser,
                      is_last: s_axis_tlast};

    md5_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    md5_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_digest(m_axis_tdata)
    );
endmodule

FILE: rtl/md5_checker.sv
`include "md5_message_digest_assert.svh"
module md5_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    logic out_stall, out_fire;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    `MD5_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid)
    `MD5_ASSERT_NEXT(a_out_hold_data, i_clk, i_rst_n, out_stall, $stable(m_axis_tdata))
    `MD5_ASSERT_NEXT(a_out_drop, i_clk, i_rst_n, out_fire, !m_axis_tvalid)
    `MD5_ASSERT_IMPL(a_out_known, i_clk, i_rst_n, m_axis_tvalid, !$isunknown(m_axis_tdata))
endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);

FILE: tb/md5_digest_checker.sv
`timescale 1ns / 1ps

module md5_digest_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [7:0]   i_s_data,
    input  logic         i_s_user,
    input  logic         i_s_last,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [127:0] i_m_data,
    output int           o_fail_count,
    output int           o_pending
);
    logic [31:0] sine_tab [64];
    logic [4:0]  shift_tab [16];
    logic [31:0] msg_words [16];
    logic [31:0] chain [4];
    logic [63:0] byte_total;
    logic [127:0] digest_q [$];

    initial begin
        sine_tab = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        shift_tab = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        fresh_message();
    end

    function automatic logic [31:0] rotl(logic [31:0] x, logic [4:0] n);
        return (x << n) | (x >> (6'd32 - n));
    endfunction

    task automatic fresh_message();
        chain[0] = md5_pkg::INIT_A;
        chain[1] = md5_pkg::INIT_B;
        chain[2] = md5_pkg::INIT_C;
        chain[3] = md5_pkg::INIT_D;
        foreach (msg_words[i]) msg_words[i] = '0;
        byte_total = '0;
    endtask

    task automatic compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            t = a + f + sine_tab[i] + msg_words[g];
            a = d; d = c; c = b;
            b = b + rotl(t, shift_tab[((i / 16) * 4) + (i % 4)]);
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic place_byte(int pos, logic [7:0] val);
        if (pos % 4 == 0) msg_words[pos / 4] = {24'h0, val};
        else msg_words[pos / 4][8 * (pos % 4) +: 8] = val;
    endtask

    task automatic absorb_request(logic [7:0] val, logic has_byte, logic last);
        int pos;
        logic [63:0] bit_len;
        if (has_byte) begin
            pos = int'(byte_total[5:0]);
            place_byte(pos, val);
            byte_total++;
            if (pos == 63) compress();
        end
        if (last) begin
            pos = int'(byte_total[5:0]);
            place_byte(pos, md5_pkg::PAD_BYTE);
            for (int w = pos / 4 + 1; w < 16; w++) msg_words[w] = '0;
            if (pos >= 56) begin
                compress();
                foreach (msg_words[i]) msg_words[i] = '0;
            end
            bit_len = byte_total << 3;
            if (md5_pkg::LENGTH_BITS < 64)
                bit_len &= (64'd1 << md5_pkg::LENGTH_BITS) - 1;
            msg_words[14] = bit_len[31:0];
            msg_words[15] = bit_len[63:32];
            compress();
            digest_q.push_back({chain[3], chain[2], chain[1], chain[0]});
            fresh_message();
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && i_s_valid && i_s_ready)
            absorb_request(i_s_data, i_s_user, i_s_last);
        if (i_rst_n && i_m_valid && i_m_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest %h", i_m_data);
                o_fail_count++;
            end else begin
                want = digest_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (want[32 * k +: 32] !== i_m_data[32 * k +: 32]) begin
                        $error("digest_word%0d expected %h actual %h", k,
                            want[32 * k +: 32], i_m_data[32 * k +: 32]);
                        o_fail_count++;
                    end
            end
        end
        o_pending = digest_q.size();
    end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    int fail_count, pending;
    int send_idle_pct = 28, recv_idle_pct = 49;
    int item_count, idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    md5_message_digest dut (.*);

    md5_digest_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser), .i_s_last(s_axis_tlast),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL md5_message_digest");
            $finish;
        end
    end

    task automatic send_request(logic [7:0] val, logic has_byte, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= val;
        s_axis_tuser <= has_byte;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        item_count++;
    endtask

    task automatic send_message(int len, bit empty_tail);
        for (int i = 0; i < len; i++)
            send_request($urandom_range(255), 1, (i == len - 1) && !empty_tail);
        if (empty_tail || len == 0) send_request($urandom_range(255), 0, 1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(9);
        if (r < 3) return $urandom_range(50, 70);
        if (r < 5) return $urandom_range(114, 130);
        return $urandom_range(0, 40);
    endfunction

    initial begin
        int len;
        item_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty message, boundary lengths, byte extremes, ignored items
        send_request(8'h00, 0, 1);
        send_request(8'h00, 1, 0);
        send_request(8'hff, 1, 0);
        send_request(8'h55, 0, 0);
        send_request(8'haa, 1, 1);
        send_message(55, 0);
        send_message(56, 1);
        // every expected digest out before going on
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        send_message(64, 0);
        send_message(63, 1);
        while (item_count < 1650) begin
            if (item_count > 550) begin
                send_idle_pct = 49;
                recv_idle_pct = 28;
            end
            if (item_count > 1100) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            len = pick_len();
            if ($urandom_range(9) == 0) send_request($urandom_range(255), 0, 0);
            send_message(len, $urandom_range(3) == 0);
        end
        s_axis_tvalid <= 0;
        recv_idle_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("PASS md5_message_digest");
        else $display("FAIL md5_message_digest");
        $finish;
    end
endmodule
